// File: design/khc_pkg.sv
// Shared types and constants for the k-mer hit counter.
`default_nettype none

package khc_pkg;

   localparam int KEY_W      = 64;
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 32;
   localparam int USED_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_COUNT = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_DUP    = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   // One request travelling down the cell chain, with its partial result.
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [SLOT_W-1:0]  slot;
      logic               done;    // some cell already handled the beat
      logic               hit;
      status_type         status;
      logic [KEY_W-1:0]   ekey;
      logic [COUNT_W-1:0] ecount;
      logic               add;     // a new entry was taken
   } tok_type;

endpackage

`default_nettype wire

// File: design/kmer_hit_counter_top.sv
// Top level of the k-mer hit counter: cell chain, entry count and result register.
// A request beat passes through every cell register in turn, then the result register.
// Throughput: one beat per cycle when not stalled; each slot is a cell and a beat visits one cell per advance.
// A stalled response holds the whole chain, so request stall follows response stall.
// Reset (synchronous, active high) empties every slot, clears the entry count and
// drops all beats in flight; keys and counts are left as they were.
`default_nettype none

module kmer_hit_counter_top #(
   parameter int TABLE_ENTRIES = 64,
   parameter int KEY_BITS      = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [63:0] req_key,
   input  wire logic [5:0]  req_slot,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_hit,
   output      logic [1:0]  rsp_status,
   output      logic [63:0] rsp_entry_key,
   output      logic [31:0] rsp_entry_count,
   output      logic [6:0]  rsp_entries_used
);
   import khc_pkg::*;

   localparam int UW = $clog2(TABLE_ENTRIES + 1);

   // Chain links: link 0 is the incoming beat, link TABLE_ENTRIES leaves the last cell.
   tok_type            link [TABLE_ENTRIES+1];
   tok_type            head;
   tok_type            tail;
   logic               advance;
   logic [KEY_W-1:0]   key_mask;

   logic [UW-1:0]      used_ff;
   logic [UW-1:0]      used_in;
   logic [31:0]        used_wide;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   status_type         rsp_status_ff;
   status_type         fin_status;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [USED_OUT_W-1:0] rsp_used_ff;

   // The chain moves whenever the result register is free or being emptied.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Keys are kept to KEY_BITS; upper bits never take part in a compare.
   assign key_mask = KEY_W'({KEY_BITS{1'b1}});

   always_comb begin
      head        = '0;
      head.valid  = req_valid;
      head.op     = op_type'(req_opcode);
      head.key    = req_key & key_mask;
      head.slot   = req_slot;
      head.status = ST_OK;
   end

   assign link[0] = head;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      khc_cell #(
         .INDEX    (i),
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (link[i]),
         .tok_out (link[i+1])
      );
   end

   assign tail = link[TABLE_ENTRIES];

   // A beat no cell took: load found no free slot, read named no slot in the table; count and no-op beats stay OK.
   always_comb begin
      fin_status = tail.status;
      if (!tail.done) begin
         unique case (tail.op)
            OP_LOAD:  fin_status = ST_FULL;
            OP_READ:  fin_status = ST_UNUSED;
            OP_COUNT: fin_status = ST_OK;
            OP_NOP:   fin_status = ST_OK;
         endcase
      end
   end

   // Entry count follows loads in the order they leave the chain.
   assign used_in   = used_ff + UW'(tail.valid && tail.add);
   assign used_wide = 32'(used_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         used_ff      <= used_in;
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.valid) begin
         rsp_hit_ff    <= tail.hit;
         rsp_status_ff <= fin_status;
         rsp_key_ff    <= tail.ekey;
         rsp_count_ff  <= tail.ecount;
         rsp_used_ff   <= used_wide[USED_OUT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_key    = rsp_key_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_entries_used = rsp_used_ff;

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_ENTRIES))
      else $error("entry count exceeds table size");

   a_add_room: assert property (@(posedge clock) disable iff (reset)
      tail.valid && tail.add |-> used_ff < UW'(TABLE_ENTRIES))
      else $error("slot taken with table already full");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_status_ff == ST_OK)
      else $error("hit reported with error status");
`endif

endmodule

`default_nettype wire

// File: design/khc_cell.sv
// One table slot: holds a key and its count, serves the beat passing through.
`default_nettype none

module khc_cell #(
   parameter int INDEX    = 0,
   parameter int KEY_BITS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire khc_pkg::tok_type tok_in,
   output      khc_pkg::tok_type tok_out
);
   import khc_pkg::*;

   localparam logic [31:0] IDX32 = 32'(INDEX);

   tok_type             tok_ff;
   tok_type             tok_in_next;
   logic                occ_ff;
   logic                occ_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [COUNT_W-1:0]  count_inc;
   logic                match;
   logic                slot_sel;

   always_comb begin
      tok_in_next = tok_in;
      occ_in      = occ_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      match       = occ_ff && (key_ff == tok_in.key[KEY_BITS-1:0]);
      slot_sel    = (32'(tok_in.slot) == IDX32);
      count_inc   = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);

      if (tok_in.valid && !tok_in.done) begin
         unique case (tok_in.op)
            OP_LOAD: begin
               if (match) begin
                  count_in           = '0;
                  tok_in_next.done   = 1'b1;
                  tok_in_next.status = ST_DUP;
                  tok_in_next.ekey   = tok_in.key;
               end else if (!occ_ff) begin
                  // first free slot, and no earlier slot held the key
                  occ_in             = 1'b1;
                  key_in             = tok_in.key[KEY_BITS-1:0];
                  count_in           = '0;
                  tok_in_next.done   = 1'b1;
                  tok_in_next.add    = 1'b1;
                  tok_in_next.ekey   = tok_in.key;
               end
            end
            OP_COUNT: begin
               if (match) begin
                  count_in           = count_inc;
                  tok_in_next.done   = 1'b1;
                  tok_in_next.hit    = 1'b1;
                  tok_in_next.ekey   = tok_in.key;
                  tok_in_next.ecount = count_inc;
               end
            end
            OP_READ: begin
               if (slot_sel) begin
                  tok_in_next.done = 1'b1;
                  if (occ_ff) begin
                     tok_in_next.ekey   = KEY_W'(key_ff);
                     tok_in_next.ecount = count_ff;
                  end else begin
                     tok_in_next.status = ST_UNUSED;
                  end
               end
            end
            OP_NOP: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         occ_ff       <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: verif/kmer_hit_counter_top_tb.sv
// Self-checking testbench for kmer_hit_counter_top: directed and random beats vs a table model.
`timescale 1ns / 1ps

module kmer_hit_counter_top_tb;
   import khc_pkg::*;

   localparam int TABLE_ENTRIES = 64;
   localparam int KEY_BITS      = 64;
   // request to response through the cell chain, plus the result register
   localparam int PIPE_DEPTH    = TABLE_ENTRIES + 1;
   // long enough to back up the whole chain and push stall onto the request side
   localparam int LONG_HOLD     = 300;
   // a few more keys than slots, so the table fills and later loads get refused
   localparam int KEY_POOL      = 80;
   localparam int RANDOM_BEATS  = 1830;
   localparam int RUN_LIMIT_NS  = 1_000_000;

   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

   // one response beat, field for field
   typedef struct packed {
      logic                  hit;
      status_type            status;
      logic [KEY_W-1:0]      ekey;
      logic [COUNT_W-1:0]    ecount;
      logic [USED_OUT_W-1:0] used;
   } kmer_result_type;

   // Tracks the key table and hit counts, and holds the responses still owed.
   class kmer_table_tracker_type;
      logic [KEY_W-1:0]   keys   [TABLE_ENTRIES];
      logic [COUNT_W-1:0] counts [TABLE_ENTRIES];
      int                 used;
      kmer_result_type    awaited[$];
      int                 mismatches;

      function new();
         used       = 0;
         mismatches = 0;
      endfunction

      function int find_slot(logic [KEY_W-1:0] key);
         for (int i = 0; i < used; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      // Apply one accepted request beat and queue the response it owes.
      function void note_request(op_type op, logic [KEY_W-1:0] key_in,
                                 logic [SLOT_W-1:0] slot);
         kmer_result_type  r;
         logic [KEY_W-1:0] key;
         int               idx;
         key = key_in & KEY_MASK;
         r   = '0;
         case (op)
            OP_LOAD: begin
               idx = find_slot(key);
               if (idx >= 0) begin
                  // reload keeps the slot, count back to zero; holds when full too
                  counts[idx] = '0;
                  r.status    = ST_DUP;
                  r.ekey      = key;
               end else if (used >= TABLE_ENTRIES) begin
                  r.status = ST_FULL;
               end else begin
                  keys[used]   = key;
                  counts[used] = '0;
                  used++;
                  r.ekey = key;
               end
            end
            OP_COUNT: begin
               idx = find_slot(key);
               if (idx >= 0) begin
                  if (counts[idx] != '1) counts[idx] = counts[idx] + 1'b1;
                  r.hit    = 1'b1;
                  r.ekey   = key;
                  r.ecount = counts[idx];
               end
            end
            OP_READ: begin
               if (slot < used) begin
                  r.ekey   = keys[slot];
                  r.ecount = counts[slot];
               end else begin
                  r.status = ST_UNUSED;
               end
            end
            default: ;
         endcase
         r.used = USED_OUT_W'(used);
         awaited.push_back(r);
      endfunction

      function void check_response(kmer_result_type got);
         kmer_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response beat with none owed: ",
                         "hit=%0b st=%s key=%0h cnt=%0h used=%0d"},
                        got.hit, got.status.name(), got.ekey, got.ecount, got.used);
            return;
         end
         want = awaited.pop_front();
         if (got.hit !== want.hit || got.status !== want.status || got.ekey !== want.ekey ||
             got.ecount !== want.ecount || got.used !== want.used) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: exp hit=%0b st=%s key=%0h cnt=%0h used=%0d",
                        want.hit, want.status.name(), want.ekey, want.ecount, want.used);
               $display("       got hit=%0b st=%0d key=%0h cnt=%0h used=%0d",
                        got.hit, got.status, got.ekey, got.ecount, got.used);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_opcode;
   logic [63:0]           req_key;
   logic [5:0]            req_slot;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [1:0]            rsp_status;
   logic [63:0]           rsp_entry_key;
   logic [31:0]           rsp_entry_count;
   logic [6:0]            rsp_entries_used;

   kmer_table_tracker_type table_sb = new();
   logic [KEY_W-1:0]      key_pool [KEY_POOL];
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    hold_requests;

   kmer_hit_counter_top #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status),
      .rsp_entry_key    (rsp_entry_key),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the chain hangs or a beat goes missing.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL kmer_hit_counter_top");
      $finish;
   end

   // Response side stall. Random at recv_stall_pct; each new hold request from
   // the stimulus turns into solid stall until the LONG_HOLD countdown runs out, counted here.
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_requests > holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Response monitor: values sampled at the edge are the pre-edge ones.
   always @(posedge clock) begin
      kmer_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.hit    = rsp_hit;
         got.status = status_type'(rsp_status);
         got.ekey   = rsp_entry_key;
         got.ecount = rsp_entry_count;
         got.used   = rsp_entries_used;
         table_sb.check_response(got);
      end
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Offer one request beat after idling cycle by cycle at send_idle_pct,
   // and hold it until taken.
   task automatic send_beat(op_type op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] slot);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_key    <= key;
      req_slot   <= slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      table_sb.note_request(op, key, slot);
   endtask

   // Sender goes quiet until every owed response has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Mostly pool keys so loads collide, counts hit and the table fills;
   // fresh random keys give misses and extra loads.
   task automatic send_random_beat();
      int               pick;
      op_type           op;
      logic [KEY_W-1:0] key;
      pick = $urandom_range(99);
      key  = rand_key();
      if (pick < 25) begin
         op = OP_LOAD;
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      end else if (pick < 70) begin
         op = OP_COUNT;
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      end else if (pick < 92) begin
         op = OP_READ;
      end else begin
         op = OP_NOP;
      end
      send_beat(op, key, SLOT_W'($urandom_range(63)));
   endtask

   // Extremes of key and slot, each opcode, empty-table read and count,
   // duplicate load clearing a count, reads past the used slots.
   task automatic run_directed();
      logic [KEY_W-1:0] k_ones;
      logic [KEY_W-1:0] k_alt;
      k_ones = '1;
      k_alt  = 64'hAAAA_AAAA_5555_5555;
      send_beat(OP_READ,  '0,     6'd0);
      send_beat(OP_COUNT, k_ones, 6'd0);
      send_beat(OP_NOP,   k_ones, 6'd63);
      send_beat(OP_LOAD,  '0,     6'd63);
      send_beat(OP_LOAD,  k_ones, 6'd0);
      send_beat(OP_LOAD,  k_ones, 6'd0);
      send_beat(OP_COUNT, k_ones, 6'd0);
      send_beat(OP_COUNT, k_ones, 6'd63);
      send_beat(OP_COUNT, '0,     6'd0);
      send_beat(OP_COUNT, k_alt,  6'd0);
      send_beat(OP_READ,  k_ones, 6'd0);
      send_beat(OP_READ,  '0,     6'd1);
      send_beat(OP_READ,  '0,     6'd2);
      send_beat(OP_READ,  k_ones, 6'd63);
      send_beat(OP_LOAD,  '0,     6'd0);
      send_beat(OP_READ,  '0,     6'd0);
      send_beat(OP_LOAD,  k_alt,  6'd42);
      send_beat(OP_COUNT, k_alt,  6'd21);
      send_beat(OP_NOP,   '0,     6'd0);
      send_beat(OP_READ,  '0,     6'd2);
   endtask

   initial begin
      int k;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_NOP;
      req_key        = '0;
      req_slot       = '0;
      hold_requests  = 0;
      send_idle_pct  = 20;
      recv_stall_pct = 66;
      for (k = 0; k < KEY_POOL; k++) key_pool[k] = rand_key();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // light sender gaps, heavy receiver stall
      run_directed();
      drain_results();
      for (k = 0; k < RANDOM_BEATS / 3; k++) send_random_beat();
      drain_results();

      // heavy sender gaps, light receiver stall
      send_idle_pct  = 66;
      recv_stall_pct = 20;
      for (k = 0; k < RANDOM_BEATS / 3; k++) send_random_beat();
      drain_results();

      // back to back, opening with a long receiver hold so the chain fills
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      for (k = 0; k < RANDOM_BEATS - 2 * (RANDOM_BEATS / 3); k++) send_random_beat();
      drain_results();

      // let any stray beat still in the chain show up
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (table_sb.mismatches == 0 && table_sb.awaited.size() == 0) begin
         $display("PASS kmer_hit_counter_top");
      end else begin
         $display("FAIL kmer_hit_counter_top");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/khc_pkg.sv
design/khc_cell.sv
design/kmer_hit_counter_top.sv
verif/kmer_hit_counter_top_tb.sv
